@@ rtl/core/uvr_pkg.sv @@
// Shared types, constants and sequence checks for the UTF-8 validate and replace block.
package uvr_pkg;

  localparam logic [7:0] Rep0 = 8'hef;
  localparam logic [7:0] Rep1 = 8'hbf;
  localparam logic [7:0] Rep2 = 8'hbd;
  localparam logic [7:0] ByteE0 = 8'he0;
  localparam logic [7:0] ByteED = 8'hed;
  localparam logic [7:0] ByteEF = 8'hef;
  localparam logic [7:0] ByteF0 = 8'hf0;
  localparam logic [7:0] ByteF4 = 8'hf4;
  localparam logic [7:0] Byte8F = 8'h8f;
  localparam logic [7:0] ByteBE = 8'hbe;
  localparam logic [7:0] ByteBF = 8'hbf;
  localparam logic [7:0] MaskFE = 8'hfe;
  localparam logic [7:0] ByteC0 = 8'hc0;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_DATA = 2'd1,
    KIND_REP  = 2'd2
  } kind_e;

  typedef struct packed {
    logic            rep_a;
    kind_e           kind;
    logic [2:0]      len;
    logic [3:0][7:0] bytes;
    logic            status;
    logic            bad;
  } cmd_t;

  function automatic logic seq_ok(input logic [2:0] n, input logic [7:0] s0,
                                  input logic [7:0] s1, input logic [7:0] s2);
    logic ok;
    ok = 1'b1;
    if (n == 3'd2) begin
      ok = (s0 & MaskFE) != ByteC0;
    end else if (n == 3'd3) begin
      if (s0 == ByteE0 && s1[7:5] == 3'b100) ok = 1'b0;
      if (s0 == ByteED && s1[7:5] == 3'b101) ok = 1'b0;
      if (s0 == ByteEF && s1 == ByteBF && (s2 & MaskFE) == ByteBE) ok = 1'b0;
    end else begin
      if (s0 == ByteF0 && s1[7:4] == 4'b1000) ok = 1'b0;
      if (s0 == ByteF4 && s1 > Byte8F) ok = 1'b0;
      if (s0 > ByteF4) ok = 1'b0;
    end
    return ok;
  endfunction

endpackage

@@ rtl/core/uvr_front.sv @@
// Front stage: accepts bytes, gathers multi-byte sequences and classifies them into commands.
module uvr_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  input  logic            cfg_strict_mode_i,
  input  logic            in_valid_i,
  input  logic [7:0]      in_byte_i,
  input  logic            last_i,
  input  logic            q_full_i,
  output logic            in_stall_o,
  output logic            push_o,
  output uvr_pkg::cmd_t   cmd_o
);

  logic            strict_q;
  logic            err_q, err_d;
  logic [1:0]      pcnt_q, pcnt_d;
  logic [2:0]      elen_q, elen_d;
  logic [2:0][7:0] pb_q, pb_d;
  logic            accept;
  logic            do_start;
  logic [2:0]      lead_len;
  logic [2:0]      n;
  logic [7:0]      s1, s2, s3;
  uvr_pkg::cmd_t   cmd;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;

  always_comb begin
    if (in_byte_i[7:5] == 3'b110) begin
      lead_len = 3'd2;
    end else if (in_byte_i[7:4] == 4'b1110) begin
      lead_len = 3'd3;
    end else if (in_byte_i[7:3] == 5'b11110) begin
      lead_len = 3'd4;
    end else begin
      lead_len = 3'd0;
    end
  end

  assign n  = {1'b0, pcnt_q} + 3'd1;
  assign s1 = (n == 3'd2) ? in_byte_i : pb_q[1];
  assign s2 = (n == 3'd3) ? in_byte_i : pb_q[2];
  assign s3 = (n == 3'd4) ? in_byte_i : 8'h00;

  always_comb begin
    cmd      = '0;
    err_d    = err_q;
    pcnt_d   = pcnt_q;
    elen_d   = elen_q;
    pb_d     = pb_q;
    do_start = 1'b0;
    if (!err_q) begin
      if (pcnt_q == 2'd0) begin
        do_start = 1'b1;
      end else if (in_byte_i[7:6] == 2'b10) begin
        if (n >= elen_q || pcnt_q == 2'd3) begin
          pcnt_d = '0;
          elen_d = '0;
          pb_d   = '0;
          if (uvr_pkg::seq_ok(n, pb_q[0], s1, s2)) begin
            cmd.kind  = uvr_pkg::KIND_DATA;
            cmd.len   = n;
            cmd.bytes = {s3, s2, s1, pb_q[0]};
          end else if (strict_q) begin
            err_d = 1'b1;
          end else begin
            cmd.kind = uvr_pkg::KIND_REP;
          end
        end else begin
          pb_d[pcnt_q] = in_byte_i;
          pcnt_d       = pcnt_q + 2'd1;
        end
      end else begin
        pcnt_d   = '0;
        elen_d   = '0;
        pb_d     = '0;
        do_start = 1'b1;
        if (strict_q) begin
          err_d = 1'b1;
        end else begin
          cmd.rep_a = 1'b1;
        end
      end
      if (do_start && !err_d) begin
        if (!in_byte_i[7]) begin
          cmd.kind     = uvr_pkg::KIND_DATA;
          cmd.len      = 3'd1;
          cmd.bytes[0] = in_byte_i;
        end else if (lead_len != 3'd0) begin
          pb_d[0] = in_byte_i;
          pcnt_d  = 2'd1;
          elen_d  = lead_len;
        end else if (strict_q) begin
          err_d = 1'b1;
        end else begin
          cmd.kind = uvr_pkg::KIND_REP;
        end
      end
    end
    if (last_i) begin
      if (pcnt_d != 2'd0 && !err_d) begin
        if (strict_q) begin
          err_d = 1'b1;
        end else begin
          cmd.kind = uvr_pkg::KIND_REP;
        end
      end
      cmd.status = 1'b1;
      cmd.bad    = err_d;
      pcnt_d     = '0;
      elen_d     = '0;
      pb_d       = '0;
      err_d      = 1'b0;
    end
  end

  assign cmd_o  = cmd;
  assign push_o = accept && (cmd.rep_a || cmd.kind != uvr_pkg::KIND_NONE || cmd.status);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strict_q <= 1'b0;
      err_q    <= 1'b0;
      pcnt_q   <= '0;
      elen_q   <= '0;
      pb_q     <= '0;
    end else begin
      if (cfg_valid_i) begin
        strict_q <= cfg_strict_mode_i;
      end
      if (accept) begin
        err_q  <= err_d;
        pcnt_q <= pcnt_d;
        elen_q <= elen_d;
        pb_q   <= pb_d;
      end
    end
  end

endmodule

@@ rtl/core/uvr_fifo.sv @@
// Short command queue between the front and back stages.
module uvr_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  uvr_pkg::cmd_t push_data_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          valid_o,
  output uvr_pkg::cmd_t head_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);

  uvr_pkg::cmd_t     mem_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [PtrW:0]     cnt_q;

  assign full_o  = cnt_q == (PtrW + 1)'(Depth);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/uvr_back.sv @@
// Back stage: expands commands into output bytes and status items and keeps the counts.
module uvr_back #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  uvr_pkg::cmd_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    out_byte_o,
  output logic          has_byte_o,
  output logic          run_end_o,
  output logic          string_done_o,
  output logic          bad_data_o,
  output logic [15:0]   char_count_o,
  output logic [15:0]   byte_count_o
);

  typedef enum logic [1:0] {
    PH_A,
    PH_B,
    PH_S
  } phase_e;

  phase_e                 ph_q, ph_d, ph_cur, ph_nxt;
  logic                   mid_q, mid_d;
  logic [1:0]             idx_q, idx_d, idx_cur;
  logic [COUNT_WIDTH-1:0] chars_q, chars_d, bytes_q, bytes_d;
  logic [COUNT_WIDTH-1:0] chars_inc, bytes_inc;
  logic [COUNT_WIDTH+15:0] chars_ext, bytes_ext;
  logic                   ov_q;
  logic                   fire;
  logic [7:0]             item_byte, rep_byte;
  logic                   item_has, item_char, seg_end, item_end;

  assign fire  = q_valid_i && (!ov_q || !out_stall_i);
  assign pop_o = fire && item_end;

  always_comb begin
    if (mid_q) begin
      ph_cur  = ph_q;
      idx_cur = idx_q;
    end else begin
      idx_cur = 2'd0;
      if (head_i.rep_a) begin
        ph_cur = PH_A;
      end else if (head_i.kind != uvr_pkg::KIND_NONE) begin
        ph_cur = PH_B;
      end else begin
        ph_cur = PH_S;
      end
    end
  end

  always_comb begin
    case (idx_cur)
      2'd0:    rep_byte = uvr_pkg::Rep0;
      2'd1:    rep_byte = uvr_pkg::Rep1;
      default: rep_byte = uvr_pkg::Rep2;
    endcase
  end

  always_comb begin
    item_byte = 8'h00;
    item_has  = 1'b0;
    item_char = 1'b0;
    seg_end   = 1'b1;
    ph_nxt    = PH_S;
    item_end  = 1'b1;
    case (ph_cur)
      PH_A: begin
        item_byte = rep_byte;
        item_has  = 1'b1;
        item_char = idx_cur == 2'd0;
        seg_end   = idx_cur == 2'd2;
        if (head_i.kind != uvr_pkg::KIND_NONE) begin
          ph_nxt   = PH_B;
          item_end = 1'b0;
        end else begin
          ph_nxt   = PH_S;
          item_end = seg_end && !head_i.status;
        end
        if (!seg_end) begin
          item_end = 1'b0;
        end
      end
      PH_B: begin
        item_has  = 1'b1;
        item_char = idx_cur == 2'd0;
        if (head_i.kind == uvr_pkg::KIND_REP) begin
          item_byte = rep_byte;
          seg_end   = idx_cur == 2'd2;
        end else begin
          item_byte = head_i.bytes[idx_cur];
          seg_end   = {1'b0, idx_cur} == head_i.len - 3'd1;
        end
        ph_nxt   = PH_S;
        item_end = seg_end && !head_i.status;
      end
      default: begin
        ph_nxt   = PH_S;
        item_end = 1'b1;
      end
    endcase
  end

  assign chars_inc = (chars_q == '1) ? chars_q : chars_q + 1'b1;
  assign bytes_inc = (bytes_q == '1) ? bytes_q : bytes_q + 1'b1;

  always_comb begin
    chars_d = item_char ? chars_inc : chars_q;
    bytes_d = item_has ? bytes_inc : bytes_q;
    mid_d   = !item_end;
    ph_d    = seg_end ? ph_nxt : ph_cur;
    idx_d   = seg_end ? 2'd0 : idx_cur + 2'd1;
  end

  assign chars_ext = {16'h0000, chars_d};
  assign bytes_ext = {16'h0000, bytes_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q    <= 1'b0;
      mid_q   <= 1'b0;
      ph_q    <= PH_A;
      idx_q   <= '0;
      chars_q <= '0;
      bytes_q <= '0;
    end else begin
      if (fire) begin
        ov_q  <= 1'b1;
        mid_q <= mid_d;
        ph_q  <= ph_d;
        idx_q <= idx_d;
        if (ph_cur == PH_S) begin
          chars_q <= '0;
          bytes_q <= '0;
        end else begin
          chars_q <= chars_d;
          bytes_q <= bytes_d;
        end
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_byte_o    <= item_byte;
      has_byte_o    <= item_has;
      run_end_o     <= item_end;
      string_done_o <= ph_cur == PH_S;
      bad_data_o    <= (ph_cur == PH_S) && head_i.bad;
      char_count_o  <= chars_ext[15:0];
      byte_count_o  <= bytes_ext[15:0];
    end
  end

  assign out_valid_o = ov_q;

endmodule

@@ rtl/core/utf8_validate_and_replace_core.sv @@
// Top level of the UTF-8 validate and replace block.
// Each command passes through the queue; results leave from the back stage's output registers.
// One input byte per cycle unless the queue is full, one result per cycle unless the output
// stalls; the back stage expands a multi-result byte while the front keeps taking bytes.
// The input stalls only while the four-entry command queue is full, even in a cycle that pops it.
// Reset clears pending sequences, counts, the error flag, strict mode and the queue.
module utf8_validate_and_replace_core #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_strict_mode_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        has_byte_o,
  output logic        run_end_o,
  output logic        string_done_o,
  output logic        bad_data_o,
  output logic [15:0] char_count_o,
  output logic [15:0] byte_count_o
);

  logic          q_full, q_valid, push, pop;
  uvr_pkg::cmd_t push_cmd, head_cmd;

  assign cfg_ready_o = 1'b1;

  uvr_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_strict_mode_i (cfg_strict_mode_i),
    .in_valid_i        (in_valid_i),
    .in_byte_i         (in_byte_i),
    .last_i            (last_i),
    .q_full_i          (q_full),
    .in_stall_o        (in_stall_o),
    .push_o            (push),
    .cmd_o             (push_cmd)
  );

  uvr_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .head_o      (head_cmd)
  );

  uvr_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .head_i        (head_cmd),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .has_byte_o    (has_byte_o),
    .run_end_o     (run_end_o),
    .string_done_o (string_done_o),
    .bad_data_o    (bad_data_o),
    .char_count_o  (char_count_o),
    .byte_count_o  (byte_count_o)
  );

endmodule
